/* hdl/sha256h_pkg.sv */
// SHA-256 constants and round/schedule functions.
// No dependencies; imported by sha256_byte_stream_hasher_unit.
package sha256h_pkg;

  localparam int RoundCount = 64;
  localparam int SchedWords = 16;
  localparam int HashWords  = 8;

  typedef logic [31:0] word_t;

  localparam word_t K_TAB [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t H_INIT [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* hdl/sha256_byte_stream_hasher_unit.sv */
// SHA-256 byte-stream hasher, top level.
// Depends on sha256h_pkg (round constants, initial hash, sigma functions).

// Hashes a message that arrives one byte per input transfer (cmd 0) and,
// on a finish transfer (cmd 1), pads it, compresses the last block(s) and
// returns the eight digest words as eight output transfers, word 0 first,
// with out_last on word 7; the hasher then re-arms for a new message.
// The 64th data byte of a block starts a compression, during which the
// hasher is busy: 64 rounds, each stepping through the read phases
// PH_RD_A and PH_RD_B (set by the two read ports of the 16-word schedule
// memory), PH_W and PH_RND, then a fold of the working variables into
// the hash. A finish first writes the remaining pad words, then runs one
// compression; when 56 or more bytes are buffered a second block follows,
// with all 16 words rewritten as pad words and another compression. The
// hasher then holds the eight digest words for output transfers.
// in_ready is high only while the hasher is idle. The 16-word memory is
// both the block buffer and the rolling message schedule; bytes are
// packed four to a word before they are written.
module sha256_byte_stream_hasher_unit
  import sha256h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // round phases
  localparam logic [1:0] PH_RD_A = 2'd0;  // read w[t-2], w[t-7] (or w[t])
  localparam logic [1:0] PH_RD_B = 2'd1;  // read w[t-15], w[t-16]
  localparam logic [1:0] PH_W    = 2'd2;  // form w[t], write back (rounds 16..63)
  localparam logic [1:0] PH_RND  = 2'd3;  // round update

  logic [2:0]  state_r;
  logic [1:0]  ph_r;
  logic [5:0]  rnd_r;
  logic [3:0]  wp_r;        // pad word pointer
  logic [5:0]  fill_r;      // bytes in current block
  logic [60:0] total_r;     // message length in bytes
  logic        final_r;     // this compression belongs to a finish
  logic        extra_r;     // another padded block follows
  logic        out_valid_r;
  logic [2:0]  out_idx_r;
  word_t       h_r [HashWords];

  word_t       acc_r;       // byte packer
  word_t       acc_nxt;
  word_t       v_r [HashWords];
  word_t       w_r, tmp_r, hk_r, part_r, t2_r;
  word_t       out_word_r;

  // schedule / block memory
  word_t       wmem [SchedWords];
  word_t       rd0_r, rd1_r;
  logic [3:0]  raddr0, raddr1;
  logic        we;
  logic [3:0]  waddr;
  word_t       wdata;

  logic        in_xfer, out_xfer;
  logic        early;       // rounds 0..15 use the loaded block directly
  word_t       pad_word, pad_fill_word, w_calc, t1;
  word_t       hnew [HashWords];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_xfer  = out_valid_r && out_ready;

  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last        = (out_idx_r == 3'd7);

  assign acc_nxt = {acc_r[23:0], in_data_byte};
  // buffered bytes, then 0x80, left-justified; stale bytes shift out
  assign pad_word = {acc_r[23:0], PAD_BYTE} << {~fill_r[1:0], 3'b000};
  assign early = (rnd_r[5:4] == 2'b00);

  always_comb begin
    pad_fill_word = '0;
    if (!extra_r && wp_r == 4'd14) begin
      pad_fill_word = total_r[60:29];
    end else if (!extra_r && wp_r == 4'd15) begin
      pad_fill_word = {total_r[28:0], 3'b000};
    end
  end

  assign w_calc = early ? tmp_r : tmp_r + small_sig0(rd0_r) + rd1_r;
  assign t1 = part_r + w_r;

  always_comb begin
    for (int i = 0; i < HashWords; i++) begin
      hnew[i] = h_r[i] + v_r[i];
    end
  end

  // memory read addresses
  always_comb begin
    raddr0 = rnd_r[3:0];
    raddr1 = rnd_r[3:0] - 4'd7;
    if (ph_r == PH_RD_A) begin
      raddr0 = early ? rnd_r[3:0] : rnd_r[3:0] - 4'd2;
    end else begin
      raddr0 = rnd_r[3:0] - 4'd15;
      raddr1 = rnd_r[3:0];
    end
  end

  // single write port: byte packer, pad sequencer or schedule update
  always_comb begin
    we    = 1'b0;
    waddr = fill_r[5:2];
    wdata = acc_nxt;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_cmd) begin
          we    = 1'b1;
          wdata = pad_word;
        end else if (in_xfer && fill_r[1:0] == 2'b11) begin
          we = 1'b1;
        end
      end
      ST_PAD: begin
        we    = 1'b1;
        waddr = wp_r;
        wdata = pad_fill_word;
      end
      ST_COMP: begin
        we    = (ph_r == PH_W) && !early;
        waddr = rnd_r[3:0];
        wdata = w_calc;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wmem[waddr] <= wdata;
    end
    rd0_r <= wmem[raddr0];
    rd1_r <= wmem[raddr1];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_RD_A;
      rnd_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      final_r     <= 1'b0;
      extra_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      for (int i = 0; i < HashWords; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          ph_r  <= PH_RD_A;
          rnd_r <= '0;
          if (in_xfer && !in_cmd) begin
            fill_r  <= fill_r + 6'd1;
            total_r <= total_r + 61'd1;
            final_r <= 1'b0;
            if (fill_r == 6'd63) begin
              state_r <= ST_COMP;
            end
          end else if (in_xfer) begin
            final_r <= 1'b1;
            extra_r <= (fill_r[5:3] == 3'b111);
            wp_r    <= fill_r[5:2] + 4'd1;
            state_r <= (fill_r[5:2] == 4'd15) ? ST_COMP : ST_PAD;
          end
        end
        ST_PAD: begin
          wp_r <= wp_r + 4'd1;
          if (wp_r == 4'd15) begin
            state_r <= ST_COMP;
          end
        end
        ST_COMP: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == PH_RND) begin
            rnd_r <= rnd_r + 6'd1;
            if (rnd_r == 6'd63) begin
              state_r <= ST_FOLD;
            end
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < HashWords; i++) begin
            h_r[i] <= hnew[i];
          end
          if (final_r && extra_r) begin
            extra_r <= 1'b0;
            wp_r    <= '0;
            state_r <= ST_PAD;
          end else if (final_r) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
            state_r     <= ST_OUT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            out_idx_r <= out_idx_r + 3'd1;
            if (out_idx_r == 3'd7) begin
              // re-arm for the next message
              out_valid_r <= 1'b0;
              fill_r      <= '0;
              total_r     <= '0;
              final_r     <= 1'b0;
              state_r     <= ST_IDLE;
              for (int i = 0; i < HashWords; i++) begin
                h_r[i] <= H_INIT[i];
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer && !in_cmd) begin
      acc_r <= acc_nxt;
    end
    if (state_r == ST_COMP) begin
      case (ph_r)
        PH_RD_A: begin
          hk_r <= v_r[7] + K_TAB[rnd_r];
        end
        PH_RD_B: begin
          tmp_r <= early ? rd0_r : small_sig1(rd0_r) + rd1_r;
        end
        PH_W: begin
          w_r    <= w_calc;
          part_r <= hk_r + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]));
          t2_r   <= big_sig0(v_r[0]) +
                    ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
        end
        PH_RND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2_r;
        end
        default: begin
          w_r <= w_r;
        end
      endcase
    end else begin
      // load working variables ahead of each compression
      for (int i = 0; i < HashWords; i++) begin
        v_r[i] <= h_r[i];
      end
    end
    if (state_r == ST_FOLD) begin
      out_word_r <= hnew[0];
    end else if (out_xfer) begin
      out_word_r <= h_r[out_idx_r + 3'd1];
    end
  end

  // checks
  a_out_only_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OUT))
    else $error("digest presented outside output state");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("input taken while digest pending");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last) |=> (in_ready && fill_r == 6'd0 && total_r == 61'd0))
    else $error("hasher not re-armed after final digest word");

  a_round_end_folds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && ph_r == PH_RND && rnd_r == 6'd63) |=> (state_r == ST_FOLD))
    else $error("compression did not end in fold");

endmodule
